@@ rtl/utf16_to_utf8_transcoder_defines.svh @@
// ---------------------------------------------------------------------------
// utf16 to utf8 transcoder assertion macros
// shared concurrent assertion forms, clocked on aclk, held off during reset
// ---------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

// same-cycle implication
`define U16U8_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("u16u8 same-cycle check failed");

// next-cycle implication
`define U16U8_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("u16u8 next-cycle check failed");

`endif

@@ rtl/u16u8_pkg.sv @@
// ---------------------------------------------------------------------------
// u16u8_pkg
// types and constants shared by the utf16 to utf8 transcoder modules
// ---------------------------------------------------------------------------
package u16u8_pkg;

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 24;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned MAX_BYTES = 4;

    localparam logic [UNIT_W-1:0]  SURR_LO   = 16'hD800;
    localparam logic [UNIT_W-1:0]  SURR_HI   = 16'hE000;
    localparam logic [UNIT_W-1:0]  SURR_MASK = 16'hFC00;
    localparam logic [UNIT_W-1:0]  HIGH_TAG  = 16'hD800;
    localparam logic [CP_W-1:0]    SUPP_BASE = 21'h10000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

    // result status codes on the output channel
    typedef enum logic [1:0] {
        STATUS_DATA  = 2'd0,
        STATUS_END   = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    // what follows the data bytes of a job
    typedef enum logic [1:0] {
        TAIL_NONE  = 2'd0,
        TAIL_END   = 2'd1,
        TAIL_ERROR = 2'd2
    } tail_t;

    // one classified word, as handed from front to back
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] data_bytes;
        logic [2:0]                       n_bytes;
        tail_t                            tail;
        logic [COUNT_W-1:0]               total;
    } job_t;

endpackage

@@ rtl/u16u8_front.sv @@
// ---------------------------------------------------------------------------
// u16u8_front
// classifies each accepted utf16 word, pairs surrogates, keeps string state
// and builds the complete result job for the back end
// ---------------------------------------------------------------------------
module u16u8_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [u16u8_pkg::UNIT_W-1:0]    code_unit,
    input  logic                            end_of_buffer,
    output logic                            push,
    output u16u8_pkg::job_t                 job
);
    import u16u8_pkg::*;

    logic               pending_reg, pending_next;
    logic [9:0]         high_bits_reg, high_bits_next;
    logic               stopped_reg, stopped_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               is_bmp;
    logic               is_high;
    logic               fail;
    logic               silent;
    logic [CP_W-1:0]    cp;
    logic [COUNT_W:0]   count_sum;
    logic [COUNT_W-1:0] count_sat;
    job_t               job_c;
    logic               job_present;

    assign is_bmp  = (code_unit < SURR_LO) || (code_unit >= SURR_HI);
    assign is_high = (code_unit & SURR_MASK) == HIGH_TAG;

    always_comb begin
        pending_next   = pending_reg;
        high_bits_next = high_bits_reg;
        stopped_next   = stopped_reg;
        count_next     = count_reg;
        job_c          = '0;
        job_c.tail     = TAIL_NONE;
        fail           = 1'b0;
        silent         = 1'b0;
        cp             = '0;
        count_sum      = '0;
        count_sat      = count_reg;
        job_present    = 1'b0;

        if (stopped_reg) begin
            // words after an end or error are dropped until the buffer ends
            if (end_of_buffer) begin
                pending_next   = 1'b0;
                high_bits_next = '0;
                stopped_next   = 1'b0;
                count_next     = '0;
            end
        end else begin
            if (is_bmp) begin
                fail = pending_reg;
                cp   = CP_W'(code_unit);
            end else if (is_high) begin
                if (pending_reg) begin
                    fail = 1'b1;
                end else begin
                    pending_next   = 1'b1;
                    high_bits_next = code_unit[9:0];
                    fail           = end_of_buffer;
                    silent         = !end_of_buffer;
                end
            end else begin
                // low surrogate; the pair can never exceed the top code point
                fail           = !pending_reg;
                cp             = CP_W'({high_bits_reg, code_unit[9:0]}) + SUPP_BASE;
                pending_next   = 1'b0;
                high_bits_next = '0;
            end

            if (fail) begin
                job_c.tail   = TAIL_ERROR;
                job_present  = 1'b1;
                stopped_next = 1'b1;
            end else if (!silent) begin
                priority if (cp == '0) begin
                    job_c.n_bytes = 3'd0;
                end else if (cp < CP_W'(21'h80)) begin
                    job_c.n_bytes       = 3'd1;
                    job_c.data_bytes[0] = cp[7:0];
                end else if (cp < CP_W'(21'h800)) begin
                    job_c.n_bytes       = 3'd2;
                    job_c.data_bytes[0] = {3'b110, cp[10:6]};
                    job_c.data_bytes[1] = {2'b10, cp[5:0]};
                end else if (cp < SUPP_BASE) begin
                    job_c.n_bytes       = 3'd3;
                    job_c.data_bytes[0] = {4'b1110, cp[15:12]};
                    job_c.data_bytes[1] = {2'b10, cp[11:6]};
                    job_c.data_bytes[2] = {2'b10, cp[5:0]};
                end else begin
                    job_c.n_bytes       = 3'd4;
                    job_c.data_bytes[0] = {5'b11110, cp[20:18]};
                    job_c.data_bytes[1] = {2'b10, cp[17:12]};
                    job_c.data_bytes[2] = {2'b10, cp[11:6]};
                    job_c.data_bytes[3] = {2'b10, cp[5:0]};
                end

                count_sum  = {1'b0, count_reg} + (COUNT_W+1)'(job_c.n_bytes);
                count_sat  = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
                count_next = count_sat;

                if ((cp == '0) || end_of_buffer) begin
                    job_c.tail   = TAIL_END;
                    job_c.total  = count_sat;
                    stopped_next = 1'b1;
                end
                job_present = (job_c.n_bytes != 3'd0) || (job_c.tail != TAIL_NONE);
            end

            // a stop on the final word clears everything for the next buffer
            if (stopped_next && end_of_buffer) begin
                pending_next   = 1'b0;
                high_bits_next = '0;
                stopped_next   = 1'b0;
                count_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 1'b0;
            high_bits_reg <= '0;
            stopped_reg   <= 1'b0;
            count_reg     <= '0;
        end else if (accept) begin
            pending_reg   <= pending_next;
            high_bits_reg <= high_bits_next;
            stopped_reg   <= stopped_next;
            count_reg     <= count_next;
        end
    end

    assign push = accept && job_present;
    assign job  = job_c;

endmodule

@@ rtl/u16u8_queue.sv @@
// ---------------------------------------------------------------------------
// u16u8_queue
// short first-in first-out queue of jobs between front and back
// ---------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  u16u8_pkg::job_t wr_job,
    output logic            full,
    input  logic            rd_en,
    output u16u8_pkg::job_t rd_job,
    output logic            not_empty
);
    import u16u8_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    job_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // pointers wrap naturally, so depth must be a power of two; the queue does not enforce it
    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    assign rd_job    = entry_reg[rd_ptr_reg];
    assign full      = count_reg == CW'(DEPTH);
    assign not_empty = count_reg != '0;

    `U16U8_ASSERT_IMPLY(a_no_overflow, aclk, aresetn, wr_en, !full)
    `U16U8_ASSERT_IMPLY(a_no_underflow, aclk, aresetn, rd_en, not_empty)
    `U16U8_ASSERT_NEXT(a_fill_tracks, aclk, aresetn, wr_en && !rd_en, not_empty)

endmodule

@@ rtl/u16u8_back.sv @@
// ---------------------------------------------------------------------------
// u16u8_back
// walks the head job one result per cycle into the output register, held while the sink stalls
// ---------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    input  u16u8_pkg::job_t                 head_job,
    output logic                            pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [u16u8_pkg::BYTE_W-1:0]    m_out_byte,
    output logic [1:0]                      m_status,
    output logic [u16u8_pkg::COUNT_W-1:0]   m_byte_total,
    output logic                            m_last_of_run
);
    import u16u8_pkg::*;

    logic [2:0]         step_reg, step_next;
    logic               valid_reg, valid_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    status_t            status_reg, status_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               last_reg, last_next;

    logic               load;
    logic [2:0]         n_results;
    logic               final_step;

    assign load       = head_valid && (!valid_reg || m_ready);
    assign n_results  = head_job.n_bytes + ((head_job.tail != TAIL_NONE) ? 3'd1 : 3'd0);
    assign final_step = step_reg == (n_results - 3'd1);
    assign pop        = load && final_step;

    always_comb begin
        step_next   = step_reg;
        valid_next  = valid_reg && !m_ready;
        byte_next   = byte_reg;
        status_next = status_reg;
        total_next  = total_reg;
        last_next   = last_reg;
        if (load) begin
            valid_next = 1'b1;
            step_next  = final_step ? 3'd0 : step_reg + 3'd1;
            last_next  = final_step;
            if (step_reg < head_job.n_bytes) begin
                byte_next   = head_job.data_bytes[step_reg[1:0]];
                status_next = STATUS_DATA;
                total_next  = '0;
            end else begin
                byte_next = '0;
                unique case (head_job.tail)
                    TAIL_END: begin
                        status_next = STATUS_END;
                        total_next  = head_job.total;
                    end
                    default: begin
                        status_next = STATUS_ERROR;
                        total_next  = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        status_reg <= status_next;
        total_reg  <= total_next;
        last_reg   <= last_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_status      = status_reg;
    assign m_byte_total  = total_reg;
    assign m_last_of_run = last_reg;

    `U16U8_ASSERT_IMPLY(a_step_in_job, aclk, aresetn, head_valid, step_reg < n_results)
    `U16U8_ASSERT_IMPLY(a_tail_byte_zero, aclk, aresetn,
        valid_reg && (status_reg != STATUS_DATA), byte_reg == '0)
    `U16U8_ASSERT_IMPLY(a_error_closes_run, aclk, aresetn,
        valid_reg && (status_reg == STATUS_ERROR), last_reg)

endmodule

@@ rtl/utf16_to_utf8_transcoder.sv @@
// ---------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// streaming utf16 to utf8 converter with surrogate pairing and end results
// ---------------------------------------------------------------------------
// each input word is one utf16 code unit plus an end-of-buffer flag; each
// output word is one result (a utf8 byte, an end marker carrying the
// saturating byte total, or an error marker), with m_last_of_run on the
// final result caused by an input word. the output side delivers one result
// per cycle while m_ready is high, set by its single-byte output register.
// a word causes no result if it is a held high surrogate or comes after the
// string has stopped, one to three for a nonzero bmp character, four for a
// surrogate pair and one more when an end result follows; a failing word
// causes a single error result. a queue of QUEUE_DEPTH classified words lets
// the input keep flowing while a long encoding drains or the sink stalls
// ---------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [u16u8_pkg::UNIT_W-1:0]    s_code_unit,
    input  logic                            s_end_of_buffer,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [u16u8_pkg::BYTE_W-1:0]    m_out_byte,
    output logic [1:0]                      m_status,
    output logic [u16u8_pkg::COUNT_W-1:0]   m_byte_total,
    output logic                            m_last_of_run
);
    import u16u8_pkg::*;

    logic s_accept;
    logic q_full;
    logic q_push;
    job_t q_wr_job;
    logic q_not_empty;
    logic q_pop;
    job_t q_head_job;

    // a word is taken whenever the queue has room, whether or not it
    // produces a result
    assign s_ready  = !q_full;
    assign s_accept = s_valid && s_ready;

    // front: surrogate pairing, string state, utf8 encoding and byte count
    u16u8_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .code_unit     (s_code_unit),
        .end_of_buffer (s_end_of_buffer),
        .push          (q_push),
        .job           (q_wr_job)
    );

    // decoupling queue of fully classified words
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (q_push),
        .wr_job    (q_wr_job),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_job    (q_head_job),
        .not_empty (q_not_empty)
    );

    // back: serialises each job into one result per cycle while the sink accepts
    u16u8_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_not_empty),
        .head_job      (q_head_job),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_status      (m_status),
        .m_byte_total  (m_byte_total),
        .m_last_of_run (m_last_of_run)
    );

endmodule

@@ dv/utf16_to_utf8_transcoder_tb.sv @@
// ---------------------------------------------------------------------------
// utf16_to_utf8_transcoder_tb
// self-checking bench for the utf16 to utf8 transcoder: a table of directed
// words, then random buffers of mostly well-formed text with some broken
// surrogate sequences mixed in. every accepted input word is run through a
// behavioural transcoder, and every accepted result is checked field by
// field against the oldest expected one. both channels idle and stall at
// random, with quiet stretches in between
// ---------------------------------------------------------------------------
module utf16_to_utf8_transcoder_tb;

    import u16u8_pkg::*;

    // words accepted by the block before the random part stops
    localparam int unsigned WORD_TARGET = 170;
    // cycles with no handshake on either side before the run is abandoned
    localparam int unsigned STALL_LIMIT = 500;
    // cycles allowed for stray results after the last expected one
    localparam int unsigned DRAIN_CYCLES = 16;

    // one result word as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        status_t            status;
        logic [COUNT_W-1:0] total;
        logic               last;
    } utf8_res_t;

    // one directed row; typed rows carry their single result in the row
    typedef struct packed {
        logic [UNIT_W-1:0]  unit;
        logic               eob;
        logic               typed;
        status_t            status;
        logic [COUNT_W-1:0] total;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [UNIT_W-1:0]    s_code_unit;
    logic                 s_end_of_buffer;
    logic                 m_valid;
    logic                 m_ready;
    logic [BYTE_W-1:0]    m_out_byte;
    logic [1:0]           m_status;
    logic [COUNT_W-1:0]   m_byte_total;
    logic                 m_last_of_run;

    // behavioural copy of the transcoder state
    bit                   pend_high;
    logic [9:0]           high_payload;
    bit                   halted;
    logic [COUNT_W-1:0]   utf8_len;

    utf8_res_t            expected_q[$];
    int unsigned          err_count;
    int unsigned          fed_words;
    int unsigned          idle_cycles;

    // extremes, every encoding length, surrogate pairing and each way a
    // string can end or fail; rows with typed = 1 hold their one result
    stim_row_t directed_rows [25] = '{
        // zero word straight after reset ends an empty string
        '{16'h0000, 1'b0, 1'b1, STATUS_END,   24'd0},
        // stopped: ignored, end of buffer clears silently
        '{16'h1234, 1'b1, 1'b0, STATUS_DATA,  24'd0},
        // one-byte extremes
        '{16'h0041, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        '{16'h007F, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        // two-byte extremes
        '{16'h0080, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        '{16'h07FF, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        // three-byte extremes
        '{16'h0800, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        '{16'hFFFF, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        // lowest and highest surrogate pairs, the second closing the buffer
        '{16'hD800, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        '{16'hDC00, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        '{16'hDBFF, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        '{16'hDFFF, 1'b1, 1'b0, STATUS_DATA,  24'd0},
        // low surrogate with no high before it
        '{16'hDC00, 1'b0, 1'b1, STATUS_ERROR, 24'd0},
        '{16'h0041, 1'b1, 1'b0, STATUS_DATA,  24'd0},
        // high surrogate followed by an ordinary character
        '{16'hD800, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        '{16'h0041, 1'b0, 1'b1, STATUS_ERROR, 24'd0},
        '{16'h0000, 1'b1, 1'b0, STATUS_DATA,  24'd0},
        // high surrogate followed by another high
        '{16'hD800, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        '{16'hD801, 1'b0, 1'b1, STATUS_ERROR, 24'd0},
        '{16'h0000, 1'b1, 1'b0, STATUS_DATA,  24'd0},
        // high surrogate as the final word of the buffer
        '{16'hDBFF, 1'b1, 1'b1, STATUS_ERROR, 24'd0},
        // high surrogate followed by a zero on the final word
        '{16'hD800, 1'b0, 1'b0, STATUS_DATA,  24'd0},
        '{16'h0000, 1'b1, 1'b1, STATUS_ERROR, 24'd0},
        // zero on the final word
        '{16'h0000, 1'b1, 1'b1, STATUS_END,   24'd0},
        // lowest non-surrogate above the gap, then the end result
        '{16'hE000, 1'b1, 1'b0, STATUS_DATA,  24'd0}
    };

    utf16_to_utf8_transcoder i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_code_unit     (s_code_unit),
        .s_end_of_buffer (s_end_of_buffer),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_status        (m_status),
        .m_byte_total    (m_byte_total),
        .m_last_of_run   (m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // behavioural transcoder
    // ---------------------------------------------------------------------

    function automatic void clear_state();
        pend_high    = 1'b0;
        high_payload = '0;
        halted       = 1'b0;
        utf8_len     = '0;
    endfunction

    function automatic void push_result(logic [BYTE_W-1:0] data, status_t status,
                                        logic [COUNT_W-1:0] total);
        utf8_res_t r;
        r.data   = data;
        r.status = status;
        r.total  = total;
        r.last   = 1'b0;
        expected_q.push_back(r);
    endfunction

    // one utf8 byte; the running length saturates
    function automatic void emit_byte(logic [BYTE_W-1:0] data);
        push_result(data, STATUS_DATA, '0);
        if (utf8_len != COUNT_MAX)
            utf8_len = utf8_len + 1'b1;
    endfunction

    // works out the results of one word and appends them to expected_q;
    // reports whether the block should simply ignore the word
    function automatic bit transcode_word(logic [UNIT_W-1:0] unit, logic eob);
        logic [CP_W-1:0] cp;
        bit              fail;
        int              q_size_at_start;
        utf8_res_t       r;
        fail            = 1'b0;
        cp              = '0;
        q_size_at_start = expected_q.size();

        // string already ended or failed: wait for the end of the buffer
        if (halted) begin
            if (eob)
                clear_state();
            return 1'b1;
        end

        if (unit < SURR_LO || unit >= SURR_HI) begin
            if (pend_high)
                fail = 1'b1;
            cp = CP_W'(unit);
        end else if ((unit & SURR_MASK) == HIGH_TAG) begin
            // high surrogate: held back until its partner arrives
            if (pend_high) begin
                fail = 1'b1;
            end else begin
                pend_high    = 1'b1;
                high_payload = unit[9:0];
                if (eob)
                    fail = 1'b1;
            end
        end else begin
            // low surrogate completes a pair, or fails on its own
            if (!pend_high)
                fail = 1'b1;
            cp           = {1'b0, high_payload, unit[9:0]} + SUPP_BASE;
            pend_high    = 1'b0;
            high_payload = '0;
            if (cp > CP_W'(21'h10FFFF))
                fail = 1'b1;
        end

        if (fail) begin
            push_result('0, STATUS_ERROR, '0);
            halted = 1'b1;
            if (eob)
                clear_state();
        end else if (pend_high) begin
            // held high surrogate, nothing to emit yet
        end else begin
            if (cp < CP_W'('h80)) begin
                if (cp != '0)
                    emit_byte(cp[7:0]);
            end else if (cp < CP_W'('h800)) begin
                emit_byte({3'b110, cp[10:6]});
                emit_byte({2'b10, cp[5:0]});
            end else if (cp < CP_W'('h10000)) begin
                emit_byte({4'b1110, cp[15:12]});
                emit_byte({2'b10, cp[11:6]});
                emit_byte({2'b10, cp[5:0]});
            end else begin
                emit_byte({5'b11110, cp[20:18]});
                emit_byte({2'b10, cp[17:12]});
                emit_byte({2'b10, cp[11:6]});
                emit_byte({2'b10, cp[5:0]});
            end
            // a zero word or the end of the buffer closes the string
            if (cp == '0 || eob) begin
                push_result('0, STATUS_END, utf8_len);
                halted = 1'b1;
                if (eob)
                    clear_state();
            end
        end

        // flag the final result caused by this word
        if (expected_q.size() > q_size_at_start) begin
            r = expected_q.pop_back();
            r.last = 1'b1;
            expected_q.push_back(r);
        end
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------------

    bit          tx_quiet;
    int unsigned tx_words;

    // presents one word and waits for it to be taken; the expectation is
    // queued as the word goes out, so a result can never beat it
    task automatic send_word(input logic [UNIT_W-1:0] unit, input logic eob,
                             input bit typed, input status_t status,
                             input logic [COUNT_W-1:0] total);
        int unsigned gap;
        int          q_size_at_start;
        // refresh the idling mode now and then, so quiet stretches occur
        if (tx_words % 12 == 0)
            tx_quiet = ($urandom_range(0, 2) == 0);
        tx_words++;
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        q_size_at_start = expected_q.size();
        void'(transcode_word(unit, eob));
        if (typed) begin
            // typed rows: the row itself states the single result
            while (expected_q.size() > q_size_at_start)
                void'(expected_q.pop_back());
            push_result('0, status, total);
            expected_q[expected_q.size() - 1].last = 1'b1;
        end
        fed_words++;
        s_valid         <= 1'b1;
        s_code_unit     <= unit;
        s_end_of_buffer <= eob;
        do @(posedge aclk); while (!s_ready);
    endtask

    // one random buffer: mostly valid text, with some zeros, lone
    // surrogates and raw words mixed in
    task automatic send_random_buffer();
        logic [UNIT_W-1:0] words[$];
        int unsigned       len;
        int unsigned       pick;
        logic [9:0]        hi;
        logic [9:0]        lo;
        len = $urandom_range(1, 10);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            hi   = 10'($urandom_range(0, 1023));
            lo   = 10'($urandom_range(0, 1023));
            if (pick < 25) begin
                words.push_back(UNIT_W'($urandom_range(1, 'h7F)));
            end else if (pick < 45) begin
                words.push_back(UNIT_W'($urandom_range('h80, 'h7FF)));
            end else if (pick < 55) begin
                words.push_back(UNIT_W'($urandom_range('h800, 'hD7FF)));
            end else if (pick < 65) begin
                words.push_back(UNIT_W'($urandom_range('hE000, 'hFFFF)));
            end else if (pick < 82) begin
                words.push_back({6'b110110, hi});
                words.push_back({6'b110111, lo});
            end else if (pick < 87) begin
                words.push_back(16'h0000);
            end else if (pick < 91) begin
                words.push_back({6'b110111, lo});
            end else if (pick < 95) begin
                words.push_back({6'b110110, hi});
            end else begin
                words.push_back(UNIT_W'($urandom_range(0, 'hFFFF)));
            end
        end
        foreach (words[i])
            send_word(words[i], i == words.size() - 1, 1'b0, STATUS_DATA, '0);
    endtask

    initial begin
        s_valid         <= 1'b0;
        s_code_unit     <= '0;
        s_end_of_buffer <= 1'b0;
        aresetn         <= 1'b0;
        err_count = 0;
        fed_words = 0;
        tx_words  = 0;
        tx_quiet  = 1'b0;
        clear_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].unit, directed_rows[i].eob, directed_rows[i].typed,
                      directed_rows[i].status, directed_rows[i].total);

        while (fed_words < WORD_TARGET)
            send_random_buffer();
        s_valid <= 1'b0;

        // let every expected result arrive, then watch for strays
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------------
    // output side
    // ---------------------------------------------------------------------

    bit          rx_quiet;
    int unsigned rx_words;

    // ready drops for a random number of cycles before each result
    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        rx_quiet = 1'b0;
        rx_words = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (rx_words % 16 == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
            rx_words++;
            stall = rx_quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // result checker: each accepted word against the oldest expectation
    always @(posedge aclk) begin
        utf8_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word byte %02h status %0d total %0d last %0b",
                         $time, m_out_byte, m_status, m_byte_total, m_last_of_run);
                err_count++;
            end else begin
                want = expected_q.pop_front();
                if (m_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, m_out_byte);
                    err_count++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_status);
                    err_count++;
                end
                if (m_byte_total !== want.total) begin
                    $display("%0t: byte_total expected %0d actual %0d",
                             $time, want.total, m_byte_total);
                    err_count++;
                end
                if (m_last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %0b actual %0b",
                             $time, want.last, m_last_of_run);
                    err_count++;
                end
            end
        end
    end

    // watchdog: gives up after a long spell with no word moving either way
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_transcoder.sv
dv/utf16_to_utf8_transcoder_tb.sv
